// ----- sv/assert_macros.svh -----
// assertion helpers used by the markov transition table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define MTT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define MTT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/mtt_pkg.sv -----
// ----------------------------------------------------------------------------
// mtt_pkg
// shared constants, codes and types of the markov transition table
// ----------------------------------------------------------------------------
package mtt_pkg;

   localparam int MAX_STATES = 64;
   localparam int MAX_SUCC   = 16;
   localparam int KEY_BITS   = 16;

   localparam int IDX_W = $clog2(MAX_STATES);
   localparam int TOT_W = IDX_W + 1;
   localparam int SUC_W = (MAX_SUCC > 1) ? $clog2(MAX_SUCC) : 1;
   localparam int LEN_W = $clog2(MAX_SUCC + 1);
   localparam int CNT_W = 16;
   localparam int SUM_W = CNT_W + SUC_W;
   localparam int RND_W = 31;
   localparam int KEY_W = 16;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_COUNT = 2'd1,
      OP_NEXT  = 2'd2,
      OP_FIRST = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   typedef struct packed {
      logic             done;
      logic             busy;
      logic [SUM_W-1:0] rem;
   } mod_result_type;

endpackage

// ----- sv/markov_transition_table.sv -----
// one transaction at a time, served by the key and successor scans and the bit-serial
// remainder unit; a new request is taken only once the last is done
// reset clears the state count, sequencer and response valid; memories keep
// their contents and unwritten entries are never read
// ----------------------------------------------------------------------------
// markov_transition_table
// learns transition counts between states and draws successors from them
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module markov_transition_table
   import mtt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_opcode,
   input  logic [KEY_W-1:0] req_new_key,
   input  logic             req_end_mark,
   input  logic [5:0]       req_from_index,
   input  logic [5:0]       req_to_index,
   input  logic [RND_W-1:0] req_random_value,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic             rsp_found,
   output logic [5:0]       rsp_result_index,
   output logic             rsp_is_end
);

   typedef enum logic [14:0] {
      S_IDLE     = 15'h0001,
      S_KEY_RD   = 15'h0002,
      S_KEY_CMP  = 15'h0004,
      S_LEN_RD   = 15'h0008,
      S_LEN_WT   = 15'h0010,
      S_ENT_RD   = 15'h0020,
      S_ENT_CMP  = 15'h0040,
      S_SUM_RD   = 15'h0080,
      S_SUM_ACC  = 15'h0100,
      S_MOD_GO   = 15'h0200,
      S_MOD_RUN  = 15'h0400,
      S_WALK_RD  = 15'h0800,
      S_WALK_CMP = 15'h1000,
      S_END_RD   = 15'h2000,
      S_DONE     = 15'h4000
   } fsm_type;

   localparam int SA_W = IDX_W + SUC_W;

   fsm_type state_ff, state_in;

   opcode_type          op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic                mark_ff;
   logic [IDX_W-1:0]    from_ff, to_ff;
   logic [RND_W-1:0]    rnd_ff;

   logic [TOT_W-1:0]    total_ff, total_in;
   logic [TOT_W-1:0]    ptr_ff, ptr_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W-1:0]    r_ff, r_in;
   logic [IDX_W-1:0]    res_ff, res_in;
   status_type          st_ff, st_in;
   logic                found_ff, found_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_st_ff;
   logic                rsp_found_ff;
   logic [IDX_W-1:0]    rsp_idx_ff;
   logic                rsp_end_ff;

   // memories
   logic [KEY_BITS-1:0]       key_mem [MAX_STATES];
   logic                      end_mem [MAX_STATES];
   logic [LEN_W-1:0]          len_mem [MAX_STATES];
   logic [IDX_W+CNT_W-1:0]    suc_mem [MAX_STATES*MAX_SUCC];

   logic [KEY_BITS-1:0] key_q;
   logic                end_q;
   logic [LEN_W-1:0]    len_q;
   logic [IDX_W-1:0]    id_q;
   logic [CNT_W-1:0]    cnt_q;

   logic                add_we;
   logic                len_we;
   logic [LEN_W-1:0]    len_wd;
   logic                suc_we;
   logic [IDX_W+CNT_W-1:0] suc_wd;
   logic [SA_W-1:0]     suc_addr;

   logic                mod_start;
   logic [SUM_W-1:0]    mod_divisor;
   mod_result_type      mod_res;

   logic                accept;
   logic                out_free;
   logic                state_idle;

   assign state_idle = (state_ff == S_IDLE);
   assign accept     = req_valid && state_idle;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign suc_addr   = {from_ff, ptr_ff[SUC_W-1:0]};
   assign mod_start  = (state_ff == S_MOD_GO);
   assign mod_divisor = (op_ff == OP_FIRST) ? SUM_W'(total_ff) : sum_ff;

   mtt_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (rnd_ff),
      .divisor  (mod_divisor),
      .result   (mod_res)
   );

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      ptr_in       = ptr_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      r_in         = r_ff;
      res_in       = res_ff;
      st_in        = st_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      add_we       = 1'b0;
      len_we       = 1'b0;
      len_wd       = '0;
      suc_we       = 1'b0;
      suc_wd       = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ptr_in   = '0;
               st_in    = ST_OK;
               found_in = 1'b0;
               case (opcode_type'(req_opcode))
                  OP_ADD: state_in = S_KEY_RD;
                  OP_COUNT: begin
                     if ({1'b0, req_from_index} >= total_ff ||
                         {1'b0, req_to_index} >= total_ff) begin
                        st_in    = ST_ABSENT;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_LEN_RD;
                     end
                  end
                  OP_NEXT: begin
                     if ({1'b0, req_from_index} >= total_ff) begin
                        st_in    = ST_ABSENT;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_LEN_RD;
                     end
                  end
                  default: begin
                     if (total_ff == '0) begin
                        st_in    = ST_EMPTY;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_MOD_GO;
                     end
                  end
               endcase
            end
         end
         S_KEY_RD: begin
            if (ptr_ff == total_ff) begin
               if (total_ff >= TOT_W'(MAX_STATES)) begin
                  st_in    = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  // append the new key as the next state
                  add_we   = 1'b1;
                  res_in   = total_ff[IDX_W-1:0];
                  total_in = total_ff + 1'b1;
                  state_in = S_END_RD;
               end
            end else begin
               state_in = S_KEY_CMP;
            end
         end
         S_KEY_CMP: begin
            if (key_q == key_ff) begin
               found_in = 1'b1;
               res_in   = ptr_ff[IDX_W-1:0];
               state_in = S_END_RD;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = S_KEY_RD;
            end
         end
         S_LEN_RD: state_in = S_LEN_WT;
         S_LEN_WT: begin
            len_in = len_q;
            ptr_in = '0;
            sum_in = '0;
            if (op_ff == OP_COUNT) begin
               state_in = S_ENT_RD;
            end else if (len_q == '0) begin
               st_in    = ST_EMPTY;
               state_in = S_DONE;
            end else begin
               state_in = S_SUM_RD;
            end
         end
         S_ENT_RD: begin
            if (ptr_ff == TOT_W'(len_ff)) begin
               if (len_ff >= LEN_W'(MAX_SUCC)) begin
                  st_in    = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  suc_we   = 1'b1;
                  suc_wd   = {to_ff, CNT_W'(1)};
                  len_we   = 1'b1;
                  len_wd   = len_ff + 1'b1;
                  res_in   = to_ff;
                  state_in = S_END_RD;
               end
            end else begin
               state_in = S_ENT_CMP;
            end
         end
         S_ENT_CMP: begin
            if (id_q == to_ff) begin
               // saturating count
               suc_we   = 1'b1;
               suc_wd   = {id_q, (cnt_q == '1) ? cnt_q : CNT_W'(cnt_q + 1'b1)};
               res_in   = to_ff;
               state_in = S_END_RD;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = S_ENT_RD;
            end
         end
         S_SUM_RD: begin
            if (ptr_ff == TOT_W'(len_ff)) begin
               if (sum_ff == '0) begin
                  st_in    = ST_EMPTY;
                  state_in = S_DONE;
               end else begin
                  state_in = S_MOD_GO;
               end
            end else begin
               state_in = S_SUM_ACC;
            end
         end
         S_SUM_ACC: begin
            sum_in   = sum_ff + SUM_W'(cnt_q);
            ptr_in   = ptr_ff + 1'b1;
            state_in = S_SUM_RD;
         end
         S_MOD_GO: state_in = S_MOD_RUN;
         S_MOD_RUN: begin
            if (mod_res.done) begin
               if (op_ff == OP_FIRST) begin
                  res_in   = mod_res.rem[IDX_W-1:0];
                  state_in = S_END_RD;
               end else begin
                  r_in     = mod_res.rem;
                  ptr_in   = '0;
                  state_in = S_WALK_RD;
               end
            end
         end
         S_WALK_RD: state_in = S_WALK_CMP;
         S_WALK_CMP: begin
            // last successor takes whatever remains
            if ((ptr_ff + 1'b1) >= TOT_W'(len_ff) || r_ff < SUM_W'(cnt_q)) begin
               res_in   = id_q;
               state_in = S_END_RD;
            end else begin
               r_in     = r_ff - SUM_W'(cnt_q);
               ptr_in   = ptr_ff + 1'b1;
               state_in = S_WALK_RD;
            end
         end
         S_END_RD: state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff   <= ptr_in;
      len_ff   <= len_in;
      sum_ff   <= sum_in;
      r_ff     <= r_in;
      res_ff   <= res_in;
      st_ff    <= st_in;
      found_ff <= found_in;
      if (accept) begin
         op_ff   <= opcode_type'(req_opcode);
         key_ff  <= req_new_key[KEY_BITS-1:0];
         mark_ff <= req_end_mark;
         from_ff <= req_from_index;
         to_ff   <= req_to_index;
         rnd_ff  <= req_random_value;
      end
      if (state_ff == S_DONE && out_free) begin
         rsp_st_ff    <= st_ff;
         rsp_found_ff <= (st_ff == ST_OK) && found_ff;
         rsp_idx_ff   <= (st_ff == ST_OK) ? res_ff : '0;
         rsp_end_ff   <= (st_ff == ST_OK) && end_q;
      end
   end

   // state memories
   always_ff @(posedge clock) begin
      if (add_we) begin
         key_mem[total_ff[IDX_W-1:0]] <= key_ff;
         end_mem[total_ff[IDX_W-1:0]] <= mark_ff;
      end
      key_q <= key_mem[ptr_ff[IDX_W-1:0]];
      if (state_ff == S_END_RD) begin
         end_q <= end_mem[res_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (add_we) begin
         len_mem[total_ff[IDX_W-1:0]] <= '0;
      end else if (len_we) begin
         len_mem[from_ff] <= len_wd;
      end
      len_q <= len_mem[from_ff];
   end

   always_ff @(posedge clock) begin
      if (suc_we) begin
         suc_mem[suc_addr] <= suc_wd;
      end
      {id_q, cnt_q} <= suc_mem[suc_addr];
   end

   assign req_stall        = !state_idle;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_result_index = rsp_idx_ff;
   assign rsp_is_end       = rsp_end_ff;

   `MTT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, !state_idle,
      "sequencer did not leave idle after a request")
   `MTT_ASSERT_NOW(a_error_fields_zero, rsp_valid && rsp_status != ST_OK,
      rsp_result_index == '0 && !rsp_found && !rsp_is_end,
      "error response carries nonzero fields")
   `MTT_ASSERT_NOW(a_total_bound, 1'b1, total_ff <= TOT_W'(MAX_STATES),
      "state count above table depth")
   `MTT_ASSERT_NOW(a_mod_only_when_waiting, mod_res.done, state_ff == S_MOD_RUN,
      "remainder finished outside its wait state")

endmodule

// ----- sv/mtt_mod_unit.sv -----
// ----------------------------------------------------------------------------
// mtt_mod_unit
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module mtt_mod_unit
   import mtt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RND_W-1:0]     dividend,
   input  logic [SUM_W-1:0]     divisor,
   output mod_result_type       result
);

   localparam int CNT_BITS = $clog2(RND_W + 1);

   logic [RND_W-1:0]    div_ff, div_in;
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]    dsr_ff, dsr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SUM_W:0]      shifted;

   assign shifted = {rem_ff, div_ff[RND_W-1]};

   always_comb begin
      div_in  = div_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         div_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_BITS'(RND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = SUM_W'(shifted - {1'b0, dsr_ff});
         end else begin
            rem_in = shifted[SUM_W-1:0];
         end
         div_in = {div_ff[RND_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign result.done = done_ff;
   assign result.busy = busy_ff;
   assign result.rem  = rem_ff;

endmodule
